// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, consequent may start with a delay
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed");

`endif

// ===== hdl/cmmpq_pkg.sv =====
// shared types and constants of the counting min-max priority queue
`default_nettype none
package cmmpq_pkg;

   localparam int KEY_WIDTH = 10;
   localparam int DEF_KEY_RANGE = 1024;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic start_ins;
      logic start_rem;
      logic give_empty;
      logic ins_upd;
      logic rem_upd;
      logic rem_scan;
      logic rem_row;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic out_free;
      logic count_zero;
      logic row_hit;
      logic next_row;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/cmmpq_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module cmmpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ===== hdl/cmmpq_ctrl.sv =====
// sequencing state machine of the priority queue
`default_nettype none
module cmmpq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_operation,
   input  wire cmmpq_pkg::sts_type sts,
   output logic                    req_stall,
   output cmmpq_pkg::cmd_type      cmd
);
   import cmmpq_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      INS_UPD,
      REM_UPD,
      REM_SCAN,
      REM_ROW
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // a remove needs a free result slot, an insert does not
   assign req_stall = (state_ff != IDLE) || ((req_operation == OP_REMOVE) && !sts.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept && (req_operation == OP_INSERT)) begin
               cmd.start_ins = 1'b1;
               state_in      = INS_UPD;
            end else if (accept && sts.empty) begin
               cmd.give_empty = 1'b1;
            end else if (accept) begin
               cmd.start_rem = 1'b1;
               state_in      = REM_UPD;
            end
         end
         INS_UPD: begin
            cmd.ins_upd = 1'b1;
            state_in    = IDLE;
         end
         REM_UPD: begin
            cmd.rem_upd = 1'b1;
            state_in    = sts.count_zero ? REM_SCAN : IDLE;
         end
         REM_SCAN: begin
            cmd.rem_scan = 1'b1;
            state_in     = (!sts.row_hit && sts.next_row) ? REM_ROW : IDLE;
         end
         REM_ROW: begin
            cmd.rem_row = 1'b1;
            state_in    = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/cmmpq_datapath.sv =====
// histogram, occupancy bitmap, bounds and result register
`default_nettype none
module cmmpq_datapath #(
   parameter int KEY_RANGE   = cmmpq_pkg::DEF_KEY_RANGE,
   parameter int COUNT_WIDTH = cmmpq_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmmpq_pkg::cmd_type                cmd,
   output cmmpq_pkg::sts_type                     sts,
   input  wire logic [cmmpq_pkg::KEY_WIDTH-1:0]   req_key,
   input  wire logic                              req_take_smallest,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic      [cmmpq_pkg::KEY_WIDTH-1:0]   rsp_removed_key,
   output logic                                   rsp_was_empty
);
   import cmmpq_pkg::*;

   localparam int KW       = $clog2(KEY_RANGE);
   localparam int ROW_LOG  = (KW <= 5) ? KW : ((KW - 8 > 5) ? KW - 8 : 5);
   localparam int ROW_BITS = 1 << ROW_LOG;
   localparam int ROWS     = (KEY_RANGE + ROW_BITS - 1) / ROW_BITS;
   localparam int RIW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW       = ROW_LOG + RIW;

   // bounds and work key
   logic [AW-1:0] low_ff, low_in, high_ff, high_in, cur_ff, cur_in;
   logic          empty_ff, empty_in;
   logic          ins_ok_ff, ins_ok_in;
   logic          small_ff, small_in;
   // row-nonzero flags, also the valid bits of the bitmap rows
   logic [ROWS-1:0]     flags_ff, flags_in;
   logic [ROW_BITS-1:0] rowv_ff, rowv_in;
   logic [RIW-1:0]      scan_row_ff, scan_row_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0] rsp_key_ff, rsp_key_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic [AW-1:0]          key_a, v_sel;
   logic                   key_ok;
   logic [RIW-1:0]         cur_row, scan_row;
   logic [ROW_LOG-1:0]     cur_bit, row_pos, ram_pos;
   logic [ROW_BITS-1:0]    onehot, rowbits, row_set, row_clr, above, below, in_row;
   logic [ROWS-1:0]        fabove, fbelow, in_flags;
   logic [COUNT_WIDTH-1:0] cnt, cnt_inc, cnt_dec;

   logic                   cnt_we, row_we;
   logic [KW-1:0]          cnt_raddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
   logic [RIW-1:0]         row_raddr;
   logic [ROW_BITS-1:0]    row_wdata, row_rdata;

   cmmpq_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(KEY_RANGE)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cur_ff[KW-1:0]),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   cmmpq_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bitmap (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (cur_row),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   assign key_a   = AW'(req_key);
   assign key_ok  = 32'(req_key) < KEY_RANGE;
   assign v_sel   = req_take_smallest ? low_ff : high_ff;
   assign cur_row = cur_ff[AW-1:ROW_LOG];
   assign cur_bit = cur_ff[ROW_LOG-1:0];

   assign cnt_raddr = cmd.start_ins ? key_a[KW-1:0] : v_sel[KW-1:0];
   assign row_raddr = cmd.rem_scan  ? scan_row :
                      (cmd.start_ins ? key_a[AW-1:ROW_LOG] : v_sel[AW-1:ROW_LOG]);

   // rows never written read as zero
   assign onehot  = ROW_BITS'(1) << cur_bit;
   assign rowbits = flags_ff[cur_row] ? row_rdata : '0;
   assign cnt     = ((rowbits & onehot) != '0) ? cnt_rdata : '0;
   assign cnt_inc = (cnt == '1) ? cnt : cnt + COUNT_WIDTH'(1);
   assign cnt_dec = (cnt != '0) ? cnt - COUNT_WIDTH'(1) : '0;
   assign row_set = rowbits | onehot;
   assign row_clr = rowbits & ~onehot;

   // search masks around the removed key
   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         above[i] = i > int'(cur_bit);
         below[i] = i < int'(cur_bit);
      end
      for (int r = 0; r < ROWS; r++) begin
         fabove[r] = r > int'(cur_row);
         fbelow[r] = r < int'(cur_row);
      end
   end

   assign in_row   = rowv_ff & (small_ff ? above : below);
   assign in_flags = flags_ff & (small_ff ? fabove : fbelow);

   // priority encoders: lowest when taking smallest, else highest
   always_comb begin
      row_pos  = '0;
      ram_pos  = '0;
      scan_row = '0;
      if (small_ff) begin
         for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (in_row[i]) row_pos = ROW_LOG'(i);
            if (row_rdata[i]) ram_pos = ROW_LOG'(i);
         end
         for (int r = ROWS - 1; r >= 0; r--) begin
            if (in_flags[r]) scan_row = RIW'(r);
         end
      end else begin
         for (int i = 0; i < ROW_BITS; i++) begin
            if (in_row[i]) row_pos = ROW_LOG'(i);
            if (row_rdata[i]) ram_pos = ROW_LOG'(i);
         end
         for (int r = 0; r < ROWS; r++) begin
            if (in_flags[r]) scan_row = RIW'(r);
         end
      end
   end

   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      empty_in     = empty_ff;
      cur_in       = cur_ff;
      ins_ok_in    = ins_ok_ff;
      small_in     = small_ff;
      flags_in     = flags_ff;
      rowv_in      = rowv_ff;
      scan_row_in  = scan_row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_key_in   = rsp_key_ff;
      rsp_empty_in = rsp_empty_ff;
      cnt_we       = 1'b0;
      cnt_wdata    = cnt_inc;
      row_we       = 1'b0;
      row_wdata    = row_set;

      if (cmd.start_ins) begin
         cur_in    = key_a;
         ins_ok_in = key_ok;
         if (key_ok && empty_ff) begin
            low_in   = key_a;
            high_in  = key_a;
            empty_in = 1'b0;
         end else if (key_ok) begin
            if (key_a < low_ff) low_in = key_a;
            if (key_a > high_ff) high_in = key_a;
         end
      end
      if (cmd.start_rem) begin
         cur_in   = v_sel;
         small_in = req_take_smallest;
      end
      if (cmd.give_empty) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = '0;
         rsp_empty_in = 1'b1;
      end
      if (cmd.ins_upd && ins_ok_ff) begin
         cnt_we            = 1'b1;
         row_we            = 1'b1;
         flags_in[cur_row] = 1'b1;
      end
      if (cmd.rem_upd) begin
         cnt_we       = 1'b1;
         cnt_wdata    = cnt_dec;
         rowv_in      = row_clr;
         rsp_valid_in = 1'b1;
         rsp_key_in   = KEY_WIDTH'(cur_ff);
         rsp_empty_in = 1'b0;
         if (cnt_dec == '0) begin
            row_we            = 1'b1;
            row_wdata         = row_clr;
            flags_in[cur_row] = |row_clr;
         end
      end
      if (cmd.rem_scan) begin
         scan_row_in = scan_row;
         if (in_row != '0) begin
            if (small_ff) low_in = {cur_row, row_pos};
            else high_in = {cur_row, row_pos};
         end else if (in_flags == '0) begin
            empty_in = 1'b1;
         end
      end
      if (cmd.rem_row) begin
         if (small_ff) low_in = {scan_row_ff, ram_pos};
         else high_in = {scan_row_ff, ram_pos};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 1'b1;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         empty_ff     <= empty_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff      <= low_in;
      high_ff     <= high_in;
      cur_ff      <= cur_in;
      ins_ok_ff   <= ins_ok_in;
      small_ff    <= small_in;
      rowv_ff     <= rowv_in;
      scan_row_ff <= scan_row_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign sts.empty      = empty_ff;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.count_zero = cnt_dec == '0;
   assign sts.row_hit    = in_row != '0;
   assign sts.next_row   = in_flags != '0;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_key = rsp_key_ff;
   assign rsp_was_empty   = rsp_empty_ff;

endmodule
`default_nettype wire

// ===== hdl/counting_min_max_priority_queue.sv =====
// insert: busy through its update state, no result; remove: result set in its update state (from idle if empty)
// remove steps: count/bitmap memory read, update, row scan, next-row read; scan and row read only when needed
// the count and bitmap memories both have registered reads
// an insert is taken while an earlier result still waits on rsp_stall, a remove is not
// reset is synchronous: clears row flags, empty mark, result valid, sequencer state; no clearing pass
`default_nettype none
`include "assert_macros.svh"
module counting_min_max_priority_queue #(
   parameter int KEY_RANGE   = cmmpq_pkg::DEF_KEY_RANGE,
   parameter int COUNT_WIDTH = cmmpq_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_operation,
   input  wire logic [cmmpq_pkg::KEY_WIDTH-1:0] req_key,
   input  wire logic                            req_take_smallest,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [cmmpq_pkg::KEY_WIDTH-1:0] rsp_removed_key,
   output logic                                 rsp_was_empty
);
   import cmmpq_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_accept;
   logic    ins_accept;
   logic    rem_on_empty;
   logic    rem_on_full;

   // sequencer: idle, update after insert, update after remove, bound scan, next-row search
   cmmpq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .sts           (sts),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   // histogram memory, occupancy bitmap rows with row flags, bounds, result slot
   cmmpq_datapath #(
      .KEY_RANGE   (KEY_RANGE),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_key           (req_key),
      .req_take_smallest (req_take_smallest),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_removed_key   (rsp_removed_key),
      .rsp_was_empty     (rsp_was_empty)
   );

   assign req_accept   = req_valid && !req_stall;
   assign ins_accept   = req_accept && (req_operation == OP_INSERT);
   assign rem_on_empty = req_accept && (req_operation == OP_REMOVE) && sts.empty;
   assign rem_on_full  = req_accept && (req_operation == OP_REMOVE) && !sts.empty;

   // a remove on an empty queue answers in the next cycle with the empty flag
   `ASSERT_NEXT(a_empty_answer, clock, reset, rem_on_empty, (rsp_valid && rsp_was_empty))
   // a remove on a filled queue answers with a key once its update state is done
   `ASSERT_NEXT(a_key_answer, clock, reset, rem_on_full, ##1 (rsp_valid && !rsp_was_empty))
   // an insert never makes a result
   `ASSERT_NEXT(a_insert_silent, clock, reset, ins_accept && !rsp_valid, !rsp_valid)
   // an insert keeps the queue busy while the memories update
   `ASSERT_NEXT(a_insert_busy, clock, reset, ins_accept, req_stall)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the counting min-max priority queue: predicting scoreboard and request drivers
`timescale 1ns / 100ps

typedef struct packed {
   logic [cmmpq_pkg::KEY_WIDTH-1:0] key;
   logic                            empty;
} removal_type;

class extreme_key_tracker;
   logic [cmmpq_pkg::DEF_COUNT_WIDTH-1:0] key_count [cmmpq_pkg::DEF_KEY_RANGE];
   int          low_key;
   int          high_key;
   bit          is_empty;
   removal_type due_removals [$];
   int          errors;

   function new();
      foreach (key_count[i]) key_count[i] = '0;
      low_key  = cmmpq_pkg::DEF_KEY_RANGE;
      high_key = 0;
      is_empty = 1'b1;
      errors   = 0;
   endfunction

   // update the histogram for one accepted request, queue the removal it yields
   function void note_request(logic op, logic [cmmpq_pkg::KEY_WIDTH-1:0] key,
                              logic smallest);
      removal_type want;
      int          taken;
      int          lo;
      int          hi;
      if (op == cmmpq_pkg::OP_INSERT) begin
         if (key_count[key] != '1) key_count[key]++;
         if (is_empty) begin
            low_key  = int'(key);
            high_key = int'(key);
            is_empty = 1'b0;
         end else begin
            if (int'(key) < low_key) low_key = int'(key);
            if (int'(key) > high_key) high_key = int'(key);
         end
      end else if (is_empty) begin
         want.key   = '0;
         want.empty = 1'b1;
         due_removals.push_back(want);
      end else begin
         taken = smallest ? low_key : high_key;
         if (key_count[taken] != '0) key_count[taken]--;
         lo = low_key;
         while (lo <= high_key && key_count[lo] == '0) lo++;
         if (lo > high_key) begin
            low_key  = cmmpq_pkg::DEF_KEY_RANGE;
            high_key = 0;
            is_empty = 1'b1;
         end else begin
            hi = high_key;
            while (hi > lo && key_count[hi] == '0) hi--;
            low_key  = lo;
            high_key = hi;
         end
         want.key   = taken[cmmpq_pkg::KEY_WIDTH-1:0];
         want.empty = 1'b0;
         due_removals.push_back(want);
      end
   endfunction

   function void check_removal(logic [cmmpq_pkg::KEY_WIDTH-1:0] key, logic empty);
      removal_type want;
      if (due_removals.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual removed_key %0d was_empty %0b",
                  $time, key, empty);
         errors++;
         return;
      end
      want = due_removals.pop_front();
      if (key !== want.key) begin
         $display("%0t: removed_key expected %0d actual %0d", $time, want.key, key);
         errors++;
      end
      if (empty !== want.empty) begin
         $display("%0t: was_empty expected %0b actual %0b", $time, want.empty, empty);
         errors++;
      end
   endfunction
endclass

module tb;
   import cmmpq_pkg::*;

   localparam int RESET_CYCLES   = 6;
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off to back up the block
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either channel
   localparam int DRAIN_CYCLES   = 16;    // settle time after the last result
   localparam int RANDOM_ITEMS   = 620;   // per random run
   localparam int DUP_COPIES     = 20;    // copies of one key in the duplicate test

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_operation;
   logic [KEY_WIDTH-1:0] req_key;
   logic                 req_take_smallest;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [KEY_WIDTH-1:0] rsp_removed_key;
   logic                 rsp_was_empty;

   extreme_key_tracker tracker = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;      // asks the receiver for one long stall
   int stored_keys = 0;      // stimulus-side occupancy, steers the insert/remove mix
   int quiet_cycles = 0;
   int window_base = 0;      // narrow key window for duplicate keys

   counting_min_max_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_take_smallest (req_take_smallest),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_key   (rsp_removed_key),
      .rsp_was_empty     (rsp_was_empty)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // handshake monitor: values seen here are the ones present at the edge
   always @(posedge clock) begin
      if (!reset) begin
         // results first, so a request taken at the same edge queues behind
         if (rsp_valid && !rsp_stall)
            tracker.check_removal(rsp_removed_key, rsp_was_empty);
         if (req_valid && !req_stall)
            tracker.note_request(req_operation, req_key, req_take_smallest);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: random stall, or one long hold-off when asked
   initial begin : receiver
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            // sender keeps offering requests meanwhile, so the block fills up
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // offer one request after a random gap, return at the edge that takes it
   task automatic send_request(input logic op, input logic [KEY_WIDTH-1:0] key,
                               input logic smallest);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_key           <= key;
      req_take_smallest <= smallest;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_INSERT)
         stored_keys++;
      else if (stored_keys > 0)
         stored_keys--;
   endtask

   // random mix that keeps the queue mostly occupied, with frequent trips to empty
   task automatic run_random(input int n_items);
      int                   i;
      int                   pick;
      int                   ins_pct;
      logic [KEY_WIDTH-1:0] k;
      for (i = 0; i < n_items; i++) begin
         if (i % 64 == 0) window_base = $urandom_range(1023 - 15);
         ins_pct = (stored_keys < 4) ? 75 : (stored_keys > 60) ? 30 : 55;
         if ($urandom_range(99) < ins_pct) begin
            pick = $urandom_range(99);
            if (pick < 40)
               k = KEY_WIDTH'(window_base + $urandom_range(15));
            else if (pick < 85)
               k = KEY_WIDTH'($urandom_range(1023));
            else if ($urandom_range(1))
               k = KEY_WIDTH'(1023 - $urandom_range(2));
            else
               k = KEY_WIDTH'($urandom_range(2));
            send_request(OP_INSERT, k, 1'($urandom_range(1)));
         end else begin
            // key is a don't-care on remove, still randomized
            send_request(OP_REMOVE, KEY_WIDTH'($urandom_range(1023)),
                         1'($urandom_range(1)));
         end
      end
   endtask

   initial begin : stimulus
      int i;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= OP_INSERT;
      req_key           <= '0;
      req_take_smallest <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles 32 of 100, receiver 46 of 100
      send_idle_pct = 32;
      recv_idle_pct = 46;

      // remove from an empty queue, both ends
      send_request(OP_REMOVE, 10'd0, 1'b1);
      send_request(OP_REMOVE, 10'd1023, 1'b0);
      // key extremes, a duplicate, then drain from both ends
      send_request(OP_INSERT, 10'd0, 1'b0);
      send_request(OP_INSERT, 10'd1023, 1'b1);
      send_request(OP_INSERT, 10'd1023, 1'b0);
      send_request(OP_INSERT, 10'd512, 1'b1);
      send_request(OP_REMOVE, 10'd1023, 1'b1);
      send_request(OP_REMOVE, 10'd0, 1'b0);
      send_request(OP_REMOVE, 10'd341, 1'b0);
      // last entry goes, queue back to empty
      send_request(OP_REMOVE, 10'd682, 1'b0);
      send_request(OP_REMOVE, 10'd1023, 1'b1);
      // single entry at the top, taken from the low end
      send_request(OP_INSERT, 10'd1023, 1'b0);
      send_request(OP_REMOVE, 10'd0, 1'b1);
      send_request(OP_REMOVE, 10'd0, 1'b0);
      // single entry at the bottom, taken from the high end
      send_request(OP_INSERT, 10'd0, 1'b1);
      send_request(OP_REMOVE, 10'd1023, 1'b0);
      // bounds move inward across a wide gap
      send_request(OP_INSERT, 10'd700, 1'b0);
      send_request(OP_INSERT, 10'd300, 1'b0);
      send_request(OP_INSERT, 10'd301, 1'b1);
      send_request(OP_REMOVE, 10'd0, 1'b1);
      send_request(OP_REMOVE, 10'd0, 1'b0);
      send_request(OP_REMOVE, 10'd0, 1'b1);
      send_request(OP_REMOVE, 10'd0, 1'b1);
      stored_keys = 0;

      // long receiver hold-off at the head of the random run
      hold_off = 1'b1;
      run_random(RANDOM_ITEMS);

      // phase two: roles swapped
      send_idle_pct = 46;
      recv_idle_pct = 32;
      run_random(RANDOM_ITEMS);

      // phase three: no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_removals.size() != 0) @(posedge clock);
      // drain whatever the random part left so the duplicate test starts from empty
      for (i = 0; i < 200 && stored_keys > 0; i++)
         send_request(OP_REMOVE, 10'd0, 1'($urandom_range(1)));
      send_request(OP_REMOVE, 10'd0, 1'b1);

      // many copies of one key, with neighbors below and above,
      // then take every copy back out
      send_request(OP_INSERT, 10'd5, 1'b0);
      for (i = 0; i < DUP_COPIES; i++)
         send_request(OP_INSERT, 10'd777, 1'($urandom_range(1)));
      send_request(OP_INSERT, 10'd1000, 1'b1);
      send_request(OP_REMOVE, KEY_WIDTH'($urandom_range(1023)), 1'b1);
      send_request(OP_REMOVE, KEY_WIDTH'($urandom_range(1023)), 1'b0);
      for (i = 0; i < DUP_COPIES; i++)
         send_request(OP_REMOVE, KEY_WIDTH'($urandom_range(1023)), i[0]);
      // every copy is gone, so this one finds the queue empty
      send_request(OP_REMOVE, KEY_WIDTH'($urandom_range(1023)), 1'b1);
      stored_keys = 0;

      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;

      // wait for every outstanding removal, then watch for strays
      while (tracker.due_removals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.due_removals.size() != 0) begin
         $display("%0t: %0d expected removals never arrived", $time,
                  tracker.due_removals.size());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cmmpq_pkg.sv
hdl/cmmpq_ram.sv
hdl/cmmpq_ctrl.sv
hdl/cmmpq_datapath.sv
hdl/counting_min_max_priority_queue.sv
sim/tb.sv
